// ===== hw/rtl/pid_controller_step_defines.svh =====
// assertion macros shared by the pid step rtl
`ifndef PID_CONTROLLER_STEP_DEFINES_SVH
`define PID_CONTROLLER_STEP_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define PCS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define PCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pcs_pkg.sv =====
// shared constants and types for the pid step block
package pcs_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned CFG_IDX_W      = 3;

  typedef enum logic {
    OP_COMPUTE = 1'b0,
    OP_PRESET  = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN  = 3'd0,
    CFG_INTEG_GAIN = 3'd1,
    CFG_DERIV_GAIN = 3'd2,
    CFG_LOW_LIMIT  = 3'd3,
    CFG_HIGH_LIMIT = 3'd4,
    CFG_INVERT     = 3'd5
  } cfg_idx_e;

  // handshake between the queue and the back end
  typedef struct packed {
    logic vld;
  } q_stat_t;

  typedef struct packed {
    logic pop;
  } q_ctrl_t;

endpackage

// ===== hw/rtl/pid_controller_step.sv =====
// top level of the pid step block: config registers, front end, queue, back end
//
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tuser: operation, tdata: meas, target, preset
// m_axis    out  m_axis_tvalid/tready       tdata: drive
// cfg       in   cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
// one item per cycle sustained while the m_axis result is not held; a result passes, in order,
// through the queue entry, product stage, integral stage and output register
// the integral feedback closes in the integral stage: one add and one clamp per cycle
// rst_ni clears gains, integral, last measurement and all valid bits and sets the limits to full range at once
// a held m_axis result stalls the back end; the queue keeps taking items until full
// config writes are always taken and act at once
module pid_controller_step
  import pcs_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // slave side
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // measurement, target, preset_output (low to high), zero padded to bytes
  input  logic [((3*DATA_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  // operation
  input  logic                                 s_axis_tuser,
  // master side
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // drive, zero padded to bytes
  output logic [((DATA_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
  // config write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]                 cfg_index_i,
  input  logic [DATA_WIDTH-1:0]                cfg_data_i
);

  localparam int unsigned DW      = DATA_WIDTH;
  localparam int unsigned OUT_W   = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int unsigned ENTRY_W = 3 * DW + 1;

  // config registers
  logic [DW-1:0] kp_q, ki_q, kd_q, lo_q, hi_q;
  logic          inv_q;
  logic          cfg_we;

  // gains after the invert option, one bit wider so the most negative gain negates exactly
  logic signed [DW:0] gain_p, gain_i, gain_d;

  // front to queue
  logic               push, q_full;
  logic [ENTRY_W-1:0] wr_entry, rd_entry;

  // queue to back
  q_stat_t q_stat;
  q_ctrl_t q_ctrl;

  logic [DW-1:0] drive;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q  <= '0;
      ki_q  <= '0;
      kd_q  <= '0;
      lo_q  <= {1'b1, {(DW-1){1'b0}}};
      hi_q  <= {1'b0, {(DW-1){1'b1}}};
      inv_q <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PROP_GAIN:  kp_q  <= cfg_data_i;
        CFG_INTEG_GAIN: ki_q  <= cfg_data_i;
        CFG_DERIV_GAIN: kd_q  <= cfg_data_i;
        CFG_LOW_LIMIT:  lo_q  <= cfg_data_i;
        CFG_HIGH_LIMIT: hi_q  <= cfg_data_i;
        CFG_INVERT:     inv_q <= cfg_data_i[0];
        default: begin
          // unused indexes are dropped
        end
      endcase
    end
  end

  function automatic logic signed [DW:0] apply_inv(input logic [DW-1:0] g, input logic inv);
    logic signed [DW:0] gx;
    gx = (DW+1)'(signed'(g));
    return inv ? -gx : gx;
  endfunction

  assign gain_p = apply_inv(kp_q, inv_q);
  assign gain_i = apply_inv(ki_q, inv_q);
  assign gain_d = apply_inv(kd_q, inv_q);

  // classify and pre-subtract
  pcs_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tuser),
    .meas_i     (s_axis_tdata[DW-1:0]),
    .target_i   (s_axis_tdata[2*DW-1:DW]),
    .preset_i   (s_axis_tdata[3*DW-1:2*DW]),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (wr_entry)
  );

  // decouples the input side from output stalls
  pcs_queue #(
    .ENTRY_W (ENTRY_W)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_data_i (wr_entry),
    .full_o    (q_full),
    .ctrl_i    (q_ctrl),
    .stat_o    (q_stat),
    .rd_data_o (rd_entry)
  );

  // products, integral and output
  pcs_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .q_ctrl_o    (q_ctrl),
    .entry_i     (rd_entry),
    .gain_p_i    (gain_p),
    .gain_i_i    (gain_i),
    .gain_d_i    (gain_d),
    .low_i       (lo_q),
    .high_i      (hi_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .drive_o     (drive)
  );

  assign m_axis_tdata = OUT_W'(drive);

endmodule

// ===== hw/rtl/pcs_front.sv =====
// front end: takes input transfers, forms saturated error and measurement change
module pcs_front
  import pcs_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned ENTRY_W    = 3 * DATA_WIDTH + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  logic [DATA_WIDTH-1:0] meas_i,
  input  logic [DATA_WIDTH-1:0] target_i,
  input  logic [DATA_WIDTH-1:0] preset_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output logic [ENTRY_W-1:0]    entry_o
);

  localparam int unsigned DW = DATA_WIDTH;

  logic [DW-1:0] prev_q, prev_d;
  logic signed [DW-1:0] err, dmeas;

  function automatic logic signed [DW-1:0] sub_sat(input logic signed [DW-1:0] a,
                                                    input logic signed [DW-1:0] b);
    logic signed [DW:0] diff;
    diff = (DW+1)'(a) - (DW+1)'(b);
    if (diff[DW] != diff[DW-1]) begin
      return diff[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
    return diff[DW-1:0];
  endfunction

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  assign err   = sub_sat(signed'(meas_i), signed'(target_i));
  assign dmeas = sub_sat(signed'(meas_i), signed'(prev_q));

  // entry layout, low to high: op, err, dmeas, preset
  assign entry_o = {preset_i, dmeas, err, op_i};

  // both item kinds load the last measurement
  assign prev_d = push_o ? meas_i : prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else begin
      prev_q <= prev_d;
    end
  end

endmodule

// ===== hw/rtl/pcs_queue.sv =====
// short queue between the front end and the back end
`include "pid_controller_step_defines.svh"
module pcs_queue
  import pcs_pkg::*;
#(
  parameter int unsigned ENTRY_W = 3 * DATA_WIDTH_DEF + 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [ENTRY_W-1:0] wr_data_i,
  output logic               full_o,
  input  q_ctrl_t            ctrl_i,
  output q_stat_t            stat_o,
  output logic [ENTRY_W-1:0] rd_data_o
);

  localparam int unsigned DEPTH = QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [ENTRY_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign stat_o.vld = (count_q != '0);
  assign pop        = ctrl_i.pop && stat_o.vld;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `PCS_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "queue count past depth")
  `PCS_ASSERT_IMPL(a_no_overflow, push_i, !full_o || pop, "push into full queue")
  `PCS_ASSERT_NEXT(a_pop_drains, pop && !push_i, count_q == $past(count_q) - 1'b1,
                   "pop did not drain")

endmodule

// ===== hw/rtl/pcs_back.sv =====
// back end: gain products, integral update, output sum and clamp, output register
`include "pid_controller_step_defines.svh"
module pcs_back
  import pcs_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  parameter int unsigned ENTRY_W    = 3 * DATA_WIDTH + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  q_stat_t               q_stat_i,
  output q_ctrl_t               q_ctrl_o,
  input  logic [ENTRY_W-1:0]    entry_i,
  input  logic [DATA_WIDTH:0]   gain_p_i,
  input  logic [DATA_WIDTH:0]   gain_i_i,
  input  logic [DATA_WIDTH:0]   gain_d_i,
  input  logic [DATA_WIDTH-1:0] low_i,
  input  logic [DATA_WIDTH-1:0] high_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DATA_WIDTH-1:0] drive_o
);

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned PW = 2 * DW + 1;
  localparam int unsigned CW = DW + 2;
  localparam logic signed [PW-1:0] MAXV = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [PW-1:0] MINV = {{(PW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  logic adv;

  // entry fields
  logic                 e_op;
  logic signed [DW-1:0] e_err, e_dmeas;
  logic [DW-1:0]        e_preset;

  // stage 1: raw products
  logic                 s1_vld_q, s1_vld_d;
  logic                 s1_op_q;
  logic signed [PW-1:0] s1_pp_q, s1_pi_q, s1_pd_q;
  logic [DW-1:0]        s1_preset_q;
  logic signed [PW-1:0] pp, pi, pd;

  // stage 2: scaled terms, integral update
  logic                 s2_vld_q, s2_vld_d;
  logic                 s2_op_q;
  logic signed [DW:0]   s2_pdsum_q;
  logic signed [DW-1:0] p_s, i_s, d_s;
  logic signed [DW-1:0] integ_q, integ_d;
  logic signed [CW-1:0] integ_sum;

  // output register
  logic                 out_vld_q, out_vld_d;
  logic [DW-1:0]        drive_q, drive_d;
  logic signed [CW-1:0] total;

  function automatic logic signed [DW-1:0] clampo(input logic signed [CW-1:0] x,
                                                   input logic signed [DW-1:0] lo,
                                                   input logic signed [DW-1:0] hi);
    logic signed [CW-1:0] lo_x, hi_x;
    lo_x = CW'(lo);
    hi_x = CW'(hi);
    if (x > lo_x) begin
      return (x < hi_x) ? x[DW-1:0] : hi;
    end
    return lo;
  endfunction

  // floor shift then saturate
  function automatic logic signed [DW-1:0] scale_sat(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] sh;
    sh = p >>> FRAC_BITS;
    if (sh > MAXV) begin
      return MAXV[DW-1:0];
    end else if (sh < MINV) begin
      return MINV[DW-1:0];
    end
    return sh[DW-1:0];
  endfunction

  // whole back end moves together unless the output is held
  assign adv          = !out_vld_q || out_ready_i;
  assign q_ctrl_o.pop = adv;

  assign e_op     = entry_i[0];
  assign e_err    = entry_i[DW:1];
  assign e_dmeas  = entry_i[2*DW:DW+1];
  assign e_preset = entry_i[3*DW:2*DW+1];

  assign pp = PW'(signed'(gain_p_i)) * PW'(e_err);
  assign pi = PW'(signed'(gain_i_i)) * PW'(e_err);
  assign pd = PW'(signed'(gain_d_i)) * PW'(e_dmeas);

  assign p_s = scale_sat(s1_pp_q);
  assign i_s = scale_sat(s1_pi_q);
  assign d_s = scale_sat(s1_pd_q);

  assign integ_sum = CW'(integ_q) + CW'(i_s);
  assign total     = CW'(s2_pdsum_q) + CW'(integ_q);

  always_comb begin
    s1_vld_d  = adv ? q_stat_i.vld : s1_vld_q;
    s2_vld_d  = adv ? s1_vld_q : s2_vld_q;
    out_vld_d = adv ? s2_vld_q : out_vld_q;
    integ_d   = integ_q;
    if (adv && s1_vld_q) begin
      if (s1_op_q == OP_PRESET) begin
        integ_d = clampo(CW'(signed'(s1_preset_q)), signed'(low_i), signed'(high_i));
      end else begin
        integ_d = clampo(integ_sum, signed'(low_i), signed'(high_i));
      end
    end
    drive_d = (s2_op_q == OP_PRESET) ? integ_q
                                     : clampo(total, signed'(low_i), signed'(high_i));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q     <= e_op;
      s1_pp_q     <= pp;
      s1_pi_q     <= pi;
      s1_pd_q     <= pd;
      s1_preset_q <= e_preset;
      s2_op_q     <= s1_op_q;
      s2_pdsum_q  <= (DW+1)'(p_s) + (DW+1)'(d_s);
      drive_q     <= drive_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      integ_q   <= '0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      s2_vld_q  <= s2_vld_d;
      out_vld_q <= out_vld_d;
      integ_q   <= integ_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign drive_o     = drive_q;

  `PCS_ASSERT_NEXT(a_s1_hold, s1_vld_q && !adv, s1_vld_q, "stage one lost item in stall")
  `PCS_ASSERT_NEXT(a_s2_to_out, s2_vld_q && adv, out_vld_q, "stage two item not delivered")
  `PCS_ASSERT_NEXT(a_preset_drive, s2_vld_q && adv && s2_op_q == OP_PRESET,
                   drive_q == $past(integ_q), "preset result differs from integral")

endmodule
